[rtl/display_color_mode_reduction_defines.svh]
// ----------------------------------------------------------------------------
// display color mode reduction assertion macros
// shared assertion forms for the color reduction pipeline
// ----------------------------------------------------------------------------
`ifndef DISPLAY_COLOR_MODE_REDUCTION_DEFINES_SVH
`define DISPLAY_COLOR_MODE_REDUCTION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DCMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DCMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dcmr_pkg.sv]
// ----------------------------------------------------------------------------
// dcmr_pkg
// types and constants of the display color mode reduction block
// ----------------------------------------------------------------------------
package dcmr_pkg;

  typedef enum logic [2:0] {
    MODE_PASS   = 3'd0,
    MODE_GRAY   = 3'd1,
    MODE_MONO   = 3'd2,
    MODE_FOUR   = 3'd3,
    MODE_RGB332 = 3'd4,
    MODE_RGB565 = 3'd5,
    MODE_RGB888 = 3'd6
  } color_mode_e;

  typedef enum logic [1:0] {
    FOUR_BLACK   = 2'd0,
    FOUR_WHITE   = 2'd1,
    FOUR_CYAN    = 2'd2,
    FOUR_MAGENTA = 2'd3
  } four_color_e;

  localparam logic [7:0]  MonoThresholdReset = 8'd120;

  // luma weights and reciprocal of 100 (exact for sums below 43690)
  localparam logic [14:0] LumaWeightR  = 15'd30;
  localparam logic [14:0] LumaWeightG  = 15'd59;
  localparam logic [14:0] LumaWeightB  = 15'd11;
  localparam logic [14:0] LumaRecip100 = 15'd20972;
  localparam int unsigned LumaShift    = 21;

  // reciprocal of 3, exact for sums below 2048
  localparam logic [9:0]  MeanRecip3   = 10'd683;
  localparam int unsigned MeanShift    = 11;

  localparam logic [23:0] ColorBlack   = 24'h000000;
  localparam logic [23:0] ColorWhite   = 24'hFFFFFF;
  localparam logic [23:0] ColorCyan    = 24'h00FFFF;
  localparam logic [23:0] ColorMagenta = 24'hFF00FF;

  localparam logic [7:0]  Mask3Bit     = 8'hE0;
  localparam logic [7:0]  Mask2Bit     = 8'hC0;
  localparam logic [7:0]  Mask5Bit     = 8'hF8;
  localparam logic [7:0]  Mask6Bit     = 8'hFC;

  // register byte addresses
  localparam logic [2:0]  AddrColorMode     = 3'd0;
  localparam logic [2:0]  AddrMonoThreshold = 3'd4;

endpackage

[rtl/display_color_mode_reduction.sv]
// ----------------------------------------------------------------------------
// display_color_mode_reduction
// converts a stream of 32-bit pixels by the selected display color mode
// ----------------------------------------------------------------------------
// One pixel in, one pixel out. Items flow through four register stages
// (input, channel sums and four-color compares, reciprocal multiplies and
// color pick, output mux), and the block sustains one pixel per clock
// while the output is not stalled. Each stage moves on when the one after
// it is empty or moving, so bubbles close up and s_axis_tready only drops
// when all four stages hold items and the output is stalled. Registers
// sit at byte address 0 (color_mode) and 4 (mono_threshold); address bit 2
// selects the register. Write them only while the pipeline is empty.
`include "display_color_mode_reduction_defines.svh"

module display_color_mode_reduction (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_in
  // pixel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pixel_out
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcmr_pkg::*;

  // ---------------------------------------------------------------- registers
  color_mode_e color_mode_q;
  logic [7:0]  mono_thr_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= MODE_PASS;
      mono_thr_q   <= MonoThresholdReset;
    end else if (cfg_wr) begin
      if (paddr[2] == AddrMonoThreshold[2]) begin
        mono_thr_q <= pwdata[7:0];
      end else begin
        color_mode_q <= color_mode_e'(pwdata[2:0]);
      end
    end
  end

  always_comb begin
    if (paddr[2] == AddrMonoThreshold[2]) begin
      prdata = {24'd0, mono_thr_q};
    end else begin
      prdata = {29'd0, color_mode_q};
    end
  end

  // ---------------------------------------------------------- stage control
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------- stage 1 input
  logic [31:0] pix1_q;

  always_ff @(posedge clk_i) begin
    if (en1) pix1_q <= s_axis_tdata;
  end

  // ------------------------------------------- stage 2 sums and compares
  logic [7:0]  r1, g1, b1;
  logic [14:0] lsum2_d, lsum2_q;
  logic [9:0]  csum2_d, csum2_q;
  logic [8:0]  gb_sum, rb_sum;
  logic [5:0]  flags2_d, flags2_q;  // w<k, c<k, m<k, c<w, m<w, m<c
  logic [31:0] pix2_q;

  assign r1 = pix1_q[23:16];
  assign g1 = pix1_q[15:8];
  assign b1 = pix1_q[7:0];

  always_comb begin
    lsum2_d = 15'(r1) * LumaWeightR + 15'(g1) * LumaWeightG + 15'(b1) * LumaWeightB;
    csum2_d = 10'(r1) + 10'(g1) + 10'(b1);
    gb_sum  = 9'(g1) + 9'(b1);
    rb_sum  = 9'(r1) + 9'(b1);
    // squared distances differ by multiples of 255, so each compare is linear
    flags2_d[0] = csum2_d >= 10'd383;
    flags2_d[1] = gb_sum[8];
    flags2_d[2] = rb_sum[8];
    flags2_d[3] = !r1[7];
    flags2_d[4] = !g1[7];
    flags2_d[5] = g1 < r1;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      lsum2_q  <= lsum2_d;
      csum2_q  <= csum2_d;
      flags2_q <= flags2_d;
      pix2_q   <= pix1_q;
    end
  end

  // ---------------------------------------- stage 3 multiplies and color pick
  logic [29:0] luma_prod;
  logic [19:0] mean_prod;
  logic [7:0]  luma3_q, mean3_q;
  logic        white3_q;
  four_color_e four3_d, four3_q;
  logic [31:0] pix3_q;

  always_comb begin
    luma_prod = 30'(lsum2_q) * 30'(LumaRecip100);
    mean_prod = 20'(csum2_q) * 20'(MeanRecip3);
    // strict compares keep ties on the earlier color
    four3_d = FOUR_BLACK;
    if (flags2_q[0]) four3_d = FOUR_WHITE;
    unique case (four3_d)
      FOUR_BLACK: if (flags2_q[1]) four3_d = FOUR_CYAN;
      default:    if (flags2_q[3]) four3_d = FOUR_CYAN;
    endcase
    unique case (four3_d)
      FOUR_BLACK: if (flags2_q[2]) four3_d = FOUR_MAGENTA;
      FOUR_WHITE: if (flags2_q[4]) four3_d = FOUR_MAGENTA;
      default:    if (flags2_q[5]) four3_d = FOUR_MAGENTA;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      luma3_q  <= luma_prod[LumaShift +: 8];
      mean3_q  <= mean_prod[MeanShift +: 8];
      white3_q <= mean_prod[MeanShift +: 8] > mono_thr_q;
      four3_q  <= four3_d;
      pix3_q   <= pix2_q;
    end
  end

  // ------------------------------------------------------ stage 4 output mux
  logic [7:0]  r3, g3, b3;
  logic [31:0] out4_d, out4_q;

  assign r3 = pix3_q[23:16];
  assign g3 = pix3_q[15:8];
  assign b3 = pix3_q[7:0];

  always_comb begin
    unique case (color_mode_q)
      MODE_GRAY:   out4_d = {8'd0, luma3_q, luma3_q, luma3_q};
      MODE_MONO:   out4_d = {8'd0, white3_q ? ColorWhite : ColorBlack};
      MODE_FOUR: begin
        unique case (four3_q)
          FOUR_BLACK:   out4_d = {8'd0, ColorBlack};
          FOUR_WHITE:   out4_d = {8'd0, ColorWhite};
          FOUR_CYAN:    out4_d = {8'd0, ColorCyan};
          FOUR_MAGENTA: out4_d = {8'd0, ColorMagenta};
          default:      out4_d = {8'd0, ColorBlack};
        endcase
      end
      MODE_RGB332: out4_d = {8'd0, r3 & Mask3Bit, g3 & Mask3Bit, b3 & Mask2Bit};
      MODE_RGB565: out4_d = {8'd0, r3 & Mask5Bit, g3 & Mask6Bit, b3 & Mask5Bit};
      MODE_RGB888: out4_d = {8'd0, pix3_q[23:0]};
      default:     out4_d = pix3_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) out4_q <= out4_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = out4_q;

  // ---------------------------------------------------------------- checks
  `DCMR_ASSERT_NEXT(a_accept_fills_input, s_axis_tvalid && s_axis_tready, v1_q,
    "accepted item did not reach the input stage")
  `DCMR_ASSERT_NOW(a_full_stall_blocks, v1_q && v2_q && v3_q && v4_q && !m_axis_tready,
    !s_axis_tready, "input taken while the pipeline is full and stalled")
  `DCMR_ASSERT_NEXT(a_luma_quotient, en3 && v2_q,
    (15'(luma3_q) * 15'd100 <= $past(lsum2_q)) &&
    ($past(lsum2_q) < 15'(luma3_q) * 15'd100 + 15'd100),
    "luma reciprocal multiply gave a wrong quotient")
  `DCMR_ASSERT_NEXT(a_mean_quotient, en3 && v2_q,
    (10'(mean3_q) * 10'd3 <= $past(csum2_q)) &&
    ($past(csum2_q) < 10'(mean3_q) * 10'd3 + 10'd3),
    "channel mean reciprocal multiply gave a wrong quotient")

endmodule

[dv/display_color_mode_reduction_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_color_mode_reduction_checker
// watches the pixel stream and register port of the color reduction block,
// predicts every output pixel from the accepted input pixels and the register
// writes seen on the port, and compares in order
// ----------------------------------------------------------------------------
module display_color_mode_reduction_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          pending_o,
  output int          failures_o
);
  import dcmr_pkg::*;

  logic [2:0]  mode_q;
  logic [7:0]  thr_q;
  logic [31:0] expected_pixels[$];
  logic [31:0] want;
  int          mismatch_count = 0;

  assign failures_o = mismatch_count;

  function automatic logic [31:0] reduce_pixel(logic [31:0] px, logic [2:0] mode,
                                               logic [7:0] thr);
    int          r, g, b, luma, mean, best;
    int          sq_err[4];
    four_color_e pick;
    logic [23:0] color;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    case (mode)
      MODE_GRAY: begin
        luma = (r * 30 + g * 59 + b * 11) / 100;
        return {8'h00, luma[7:0], luma[7:0], luma[7:0]};
      end
      MODE_MONO: begin
        mean = (r + g + b) / 3;
        return (mean > int'(thr)) ? {8'h00, ColorWhite} : {8'h00, ColorBlack};
      end
      MODE_FOUR: begin
        sq_err[FOUR_BLACK]   = r * r + g * g + b * b;
        sq_err[FOUR_WHITE]   = (255 - r) ** 2 + (255 - g) ** 2 + (255 - b) ** 2;
        sq_err[FOUR_CYAN]    = r * r + (255 - g) ** 2 + (255 - b) ** 2;
        sq_err[FOUR_MAGENTA] = (255 - r) ** 2 + g * g + (255 - b) ** 2;
        // strict compare keeps the earlier color on a tie
        pick = FOUR_BLACK;
        best = sq_err[FOUR_BLACK];
        for (int i = 1; i < 4; i++) begin
          if (sq_err[i] < best) begin
            best = sq_err[i];
            pick = four_color_e'(i);
          end
        end
        case (pick)
          FOUR_WHITE:   color = ColorWhite;
          FOUR_CYAN:    color = ColorCyan;
          FOUR_MAGENTA: color = ColorMagenta;
          default:      color = ColorBlack;
        endcase
        return {8'h00, color};
      end
      MODE_RGB332: return {8'h00, px[23:16] & Mask3Bit, px[15:8] & Mask3Bit, px[7:0] & Mask2Bit};
      MODE_RGB565: return {8'h00, px[23:16] & Mask5Bit, px[15:8] & Mask6Bit, px[7:0] & Mask5Bit};
      MODE_RGB888: return {8'h00, px[23:0]};
      default:     return px;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_px);
    $display("%0t mismatch: %s, got %08h expected %08h (mode %0d threshold %0d)",
             $time, what, got, exp_px, mode_q, thr_q);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_PASS;
      thr_q  = MonoThresholdReset;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("output item with nothing pending", m_tdata_i, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata_i !== want) begin
            report_mismatch("pixel_out", m_tdata_i, want);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_pixels.push_back(reduce_pixel(s_tdata_i, mode_q, thr_q));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          AddrColorMode:     mode_q = pwdata_i[2:0];
          AddrMonoThreshold: thr_q  = pwdata_i[7:0];
          default: ;
        endcase
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

[dv/display_color_mode_reduction_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_color_mode_reduction_test
// drives pixel streams through every color mode with random idling on both
// sides, reprograms the registers between phases, and lets the checker judge
// ----------------------------------------------------------------------------
module display_color_mode_reduction_test;
  import dcmr_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_profile_e;

  localparam int          NumPhases      = 14;
  localparam int          ItemsPerPhase  = 100;
  localparam int          DrainCycles    = 10;
  localparam int          LongHoldCycles = 60;
  localparam logic [2:0]  ModeUnused     = 3'd7;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int pending;
  int failures;

  display_color_mode_reduction dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  display_color_mode_reduction_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pending_o  (pending),
    .failures_o (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // output side: random stalls, or a long hold-off when asked for
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic void set_idling(idle_profile_e profile);
    src_idle_pct   = (profile == IDLE_SRC)  ? 73 : (profile == IDLE_BOTH) ? 15 : 0;
    sink_stall_pct = (profile == IDLE_SINK) ? 73 : (profile == IDLE_BOTH) ? 15 : 0;
  endfunction

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper bits of the write data are junk on purpose
  task automatic program_mode(input logic [2:0] mode, input logic [7:0] thr);
    reg_write(AddrColorMode, (32'($urandom) & ~32'h7) | 32'(mode));
    reg_write(AddrMonoThreshold, (32'($urandom) & ~32'hFF) | 32'(thr));
  endtask

  task automatic send_pixel(input logic [31:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // called at the edge of the last accept: drop valid, wait for every result
  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_pixel(logic [7:0] thr);
    logic [7:0] ch[3];
    logic [7:0] top;
    int         v;
    top = 8'($urandom);
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(2))
            0:       ch[i] = 8'h00;
            1:       ch[i] = 8'hFF;
            default: ch[i] = 8'($urandom);
          endcase
        end
      end
      2: begin
        // mean lands close to the mono threshold
        for (int i = 0; i < 3; i++) begin
          v = int'(thr) + int'($urandom_range(6)) - 3;
          ch[i] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : 8'(v);
        end
      end
      default: begin
        // near the four-color decision boundaries (r == g, g + b == 255)
        ch[0] = 8'($urandom);
        ch[1] = ch[0] + 8'($urandom_range(2)) - 8'd1;
        ch[2] = 8'hFF - ch[1] + 8'($urandom_range(2)) - 8'd1;
      end
    endcase
    return {top, ch[0], ch[1], ch[2]};
  endfunction

  initial begin
    logic [7:0] thr;
    idle_profile_e profile;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes in every mode value, unused mode included
    set_idling(IDLE_NONE);
    for (int m = 0; m < 8; m++) begin
      program_mode(3'(m), MonoThresholdReset);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      drain_pixels();
    end
    program_mode(ModeUnused, MonoThresholdReset);
    send_pixel(32'hA512_3456);
    drain_pixels();

    // mean equal to the threshold stays black, one above goes white
    program_mode(MODE_MONO, 8'd100);
    send_pixel(32'hAB64_6464);
    send_pixel(32'h0065_6565);
    drain_pixels();

    // four-color ties: black/cyan/magenta three-way, then cyan/magenta
    program_mode(MODE_FOUR, 8'd100);
    send_pixel(32'h0000_00FF);
    send_pixel(32'h0064_64FF);
    drain_pixels();

    for (int p = 0; p < NumPhases; p++) begin
      profile = idle_profile_e'((p / 2) % 4);
      thr = (p == 2) ? 8'd0 : (p == 10) ? 8'd255 : 8'($urandom);
      set_idling(profile);
      program_mode(3'(p % 8), thr);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 0 && i == 20) hold_req = 1'b1;
        if (p == 5 && i == 50) drain_pixels();
        send_pixel(random_pixel(thr));
      end
      drain_pixels();
    end

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
